/* hw/rtl/lle_pkg.sv */
// Shared types, field widths and codes of the LRU list engine.
package lle_pkg;

   localparam int POOL_SLOTS_DEFAULT = 64;
   localparam int MODE_W             = 2;
   localparam int SLOT_W             = 6;
   localparam int LIMIT_W            = 8;
   localparam int COUNT_W            = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_MOVE   = 2'd2,
      MODE_EVICT  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_APP_A,
      ST_APP_B,
      ST_WALK,
      ST_EMIT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [SLOT_W-1:0]  entry_slot;
      logic [LIMIT_W-1:0] evict_limit;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  evicted_slot;
      logic               slot_valid;
      logic               last;
      logic [COUNT_W-1:0] entry_count;
      logic [COUNT_W-1:0] evicted_number;
   } rsp_payload_type;

endpackage

/* hw/rtl/lle_chan_if.sv */
// Valid/ready channel carrying one payload per transfer.
interface lle_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/lru_list_engine_top.sv */
// LRU list engine: doubly linked recency list kept in two link memories.
//
//  Channel   Direction  Contents
//  req_chan  in         mode, entry_slot, evict_limit
//  rsp_chan  out        evicted_slot, slot_valid, last, entry_count, evicted_number
//
// Append goes through ST_APP_A and ST_APP_B, remove through ST_UNLINK, move through
// ST_UNLINK, ST_APP_A and ST_APP_B, and an ignored operation straight to ST_RESULT,
// where the result register loads. Bulk evict walks the next-link memory one slot per
// cycle, once to count the slots and once to emit them; the emit walk waits on rsp_chan.
// Reset sets head and tail to the sentinel and the length to zero; the link
// memories are not cleared. While rsp_chan.ready is low the result register
// holds and the sequencer waits; a new request is taken only when idle.
module lru_list_engine_top #(
   parameter int POOL_SLOTS = lle_pkg::POOL_SLOTS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   lle_chan_if.sink     req_chan,
   lle_chan_if.source   rsp_chan
);
   import lle_pkg::*;

   localparam int LW = $clog2(POOL_SLOTS + 1);
   localparam int IW = $clog2(POOL_SLOTS);
   localparam logic [LW-1:0]     SENT     = LW'(POOL_SLOTS);
   localparam logic [SLOT_W:0]   POOL_EXT = (SLOT_W + 1)'(POOL_SLOTS);

   state_type state_ff, state_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] tail_ff, tail_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] slot_ff, slot_in;
   logic          move_ff, move_in;
   logic [LW-1:0] want_ff, want_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] node_ff, node_in;
   logic [LW-1:0] first_ff, first_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   evicted_slot_ff, evicted_slot_in;
   logic                slot_valid_ff, slot_valid_in;
   logic                last_ff, last_in;
   logic [COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [COUNT_W-1:0]  evicted_number_ff, evicted_number_in;

   logic [LW-1:0] next_mem [POOL_SLOTS];
   logic [LW-1:0] prev_mem [POOL_SLOTS];
   logic [LW-1:0] next_rd_ff;
   logic [LW-1:0] prev_rd_ff;
   logic          next_re, next_we, prev_re, prev_we;
   logic [IW-1:0] next_raddr, next_waddr, prev_raddr, prev_waddr;
   logic [LW-1:0] next_wdata, prev_wdata;

   logic accept;
   logic out_free;
   logic in_pool;
   logic walk_done;
   logic emit_last;
   logic req_evict;
   logic req_skip;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign in_pool   = {1'b0, req_chan.payload.entry_slot} < POOL_EXT;
   assign walk_done = (cnt_ff == want_ff) || (node_ff >= SENT);
   assign emit_last = (LW'(want_ff + 1'b1) == cnt_ff);
   assign req_evict = (req_chan.payload.mode == MODE_EVICT);
   assign req_skip  = !in_pool ||
                      ((req_chan.payload.mode == MODE_REMOVE) && (len_ff == '0));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload.evicted_slot   = evicted_slot_ff;
   assign rsp_chan.payload.slot_valid     = slot_valid_ff;
   assign rsp_chan.payload.last           = last_ff;
   assign rsp_chan.payload.entry_count    = entry_count_ff;
   assign rsp_chan.payload.evicted_number = evicted_number_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_evict) begin
                  state_in = ST_WALK;
               end else if (req_skip) begin
                  state_in = ST_RESULT;
               end else if (req_chan.payload.mode == MODE_APPEND) begin
                  state_in = ST_APP_A;
               end else begin
                  state_in = ST_UNLINK;
               end
            end
         end
         ST_UNLINK: state_in = move_ff ? ST_APP_A : ST_RESULT;
         ST_APP_A:  state_in = ST_APP_B;
         ST_APP_B:  state_in = ST_RESULT;
         ST_WALK: begin
            if (walk_done) begin
               state_in = (cnt_ff == '0) ? ST_RESULT : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      len_in   = len_ff;
      slot_in  = slot_ff;
      move_in  = move_ff;
      want_in  = want_ff;
      cnt_in   = cnt_ff;
      node_in  = node_ff;
      first_in = first_ff;

      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      evicted_slot_in   = evicted_slot_ff;
      slot_valid_in     = slot_valid_ff;
      last_in           = last_ff;
      entry_count_in    = entry_count_ff;
      evicted_number_in = evicted_number_ff;

      next_re    = 1'b0;
      next_raddr = IW'(node_ff);
      next_we    = 1'b0;
      next_waddr = IW'(slot_ff);
      next_wdata = SENT;
      prev_re    = 1'b0;
      prev_raddr = IW'(slot_ff);
      prev_we    = 1'b0;
      prev_waddr = IW'(slot_ff);
      prev_wdata = SENT;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_in = LW'(req_chan.payload.entry_slot);
               move_in = (req_chan.payload.mode == MODE_MOVE);
               if (req_evict) begin
                  if (req_chan.payload.evict_limit < LIMIT_W'(len_ff)) begin
                     want_in = LW'(req_chan.payload.evict_limit);
                  end else begin
                     want_in = len_ff;
                  end
                  cnt_in     = '0;
                  node_in    = head_ff;
                  first_in   = head_ff;
                  next_re    = 1'b1;
                  next_raddr = IW'(head_ff);
               end else if (!req_skip && (req_chan.payload.mode != MODE_APPEND)) begin
                  next_re    = 1'b1;
                  next_raddr = IW'(req_chan.payload.entry_slot);
                  prev_re    = 1'b1;
                  prev_raddr = IW'(req_chan.payload.entry_slot);
               end
            end
         end
         ST_UNLINK: begin
            if (prev_rd_ff >= SENT) begin
               head_in = next_rd_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = IW'(prev_rd_ff);
               next_wdata = next_rd_ff;
            end
            if (next_rd_ff >= SENT) begin
               tail_in = prev_rd_ff;
            end else begin
               prev_we    = 1'b1;
               prev_waddr = IW'(next_rd_ff);
               prev_wdata = prev_rd_ff;
            end
            if (!move_ff) begin
               len_in = len_ff - 1'b1;
            end
         end
         ST_APP_A: begin
            prev_we    = 1'b1;
            prev_waddr = IW'(slot_ff);
            prev_wdata = tail_ff;
            next_we    = 1'b1;
            next_waddr = IW'(slot_ff);
            next_wdata = SENT;
         end
         ST_APP_B: begin
            if (tail_ff >= SENT) begin
               head_in = slot_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = IW'(tail_ff);
               next_wdata = slot_ff;
            end
            tail_in = slot_ff;
            if (!move_ff && (len_ff < SENT)) begin
               len_in = len_ff + 1'b1;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               if (node_ff >= SENT) begin
                  tail_in = SENT;
                  head_in = SENT;
               end else begin
                  prev_we    = 1'b1;
                  prev_waddr = IW'(node_ff);
                  prev_wdata = SENT;
                  head_in    = node_ff;
               end
               len_in     = len_ff - cnt_ff;
               want_in    = '0;
               node_in    = first_ff;
               next_re    = 1'b1;
               next_raddr = IW'(first_ff);
            end else begin
               cnt_in     = cnt_ff + 1'b1;
               node_in    = next_rd_ff;
               next_re    = 1'b1;
               next_raddr = IW'(next_rd_ff);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               evicted_slot_in   = SLOT_W'(node_ff);
               slot_valid_in     = 1'b1;
               last_in           = emit_last;
               entry_count_in    = COUNT_W'(len_ff);
               evicted_number_in = COUNT_W'(cnt_ff);
               if (!emit_last) begin
                  want_in    = want_ff + 1'b1;
                  node_in    = next_rd_ff;
                  next_re    = 1'b1;
                  next_raddr = IW'(next_rd_ff);
               end
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               evicted_slot_in   = '0;
               slot_valid_in     = 1'b0;
               last_in           = 1'b1;
               entry_count_in    = COUNT_W'(len_ff);
               evicted_number_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (next_re) begin
         next_rd_ff <= next_mem[next_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (prev_re) begin
         prev_rd_ff <= prev_mem[prev_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= SENT;
         tail_ff      <= SENT;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff           <= slot_in;
      move_ff           <= move_in;
      want_ff           <= want_in;
      cnt_ff            <= cnt_in;
      node_ff           <= node_in;
      first_ff          <= first_in;
      evicted_slot_ff   <= evicted_slot_in;
      slot_valid_ff     <= slot_valid_in;
      last_ff           <= last_in;
      entry_count_ff    <= entry_count_in;
      evicted_number_ff <= evicted_number_in;
   end

`ifndef ASSERT_OFF
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !slot_valid_ff) |-> last_ff)
      else $error("A result without an evicted slot is not marked last.");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (want_ff < cnt_ff))
      else $error("Emit index ran past the evicted count.");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= SENT)
      else $error("List length exceeds the pool size.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("Request taken while an operation is in progress.");
`endif

endmodule
